/* sv/scpm_pkg.sv */
// Shared types and constants for the servo command to PWM mapper.
// No dependencies; scpm_map, the top level and the checker import this package.
`default_nettype none

package scpm_pkg;

  // Operation codes carried by in_func.
  typedef enum logic [2:0] {
    FUNC_INIT     = 3'd0,
    FUNC_UPDATE   = 3'd1,
    FUNC_SETPOINT = 3'd2,
    FUNC_ARM      = 3'd3,
    FUNC_TICK     = 3'd4
  } func_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_OUT,
    S_PAR,
    S_SRC,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

  // One entry of the per-channel parameter memory.
  typedef struct packed {
    logic [7:0]  src;
    logic [15:0] pmin;
    logic [15:0] pmax;
    logic [15:0] pdef;
  } par_t;

  localparam int unsigned PAR_W       = $bits(par_t);
  localparam logic [31:0] ARM_HOLD_MS = 32'd500;
  localparam logic [12:0] CMD_TOP     = 13'd8191;
  localparam logic [15:0] SP_INIT     = 16'hFFFF;

endpackage

`default_nettype wire

/* sv/scpm_ram.sv */
// Single-port-write, single-port-read synchronous memory; the read data is registered.
// Entries carry a valid bit cleared by reset; an entry never written reads as zero.
`default_nettype none

module scpm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_r <= vld_r[raddr];
      end
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

`default_nettype wire

/* sv/scpm_map.sv */
// Two-stage command to pulse width mapping: multiply, then divide by 8191 and clamp.
// Depends on scpm_pkg for the parameter entry type and constants.
`default_nettype none

module scpm_map (
  input  logic                clk,
  input  logic                mul_en,
  input  logic                div_en,
  input  logic signed [15:0]  sp_val,
  input  logic                sp_ok,
  input  scpm_pkg::par_t      par,
  input  logic                disarmed,
  output logic [15:0]         pw
);
  import scpm_pkg::*;

  typedef enum logic [1:0] {SEL_DEF, SEL_LO, SEL_HI, SEL_LIN} sel_t;

  sel_t               sel_nxt, sel_r;
  logic signed [15:0] v;
  logic signed [16:0] diff;
  logic               neg_nxt, neg_r;
  logic [15:0]        dmag;
  logic [12:0]        vmag;
  logic [15:0]        lo_r, hi_r, def_r;
  logic [28:0]        mag_r;

  logic [15:0]        quo_a;
  logic [16:0]        s;
  logic [13:0]        t;
  logic               ge, rnz;
  logic [16:0]        q, qc;
  logic signed [17:0] res, rmin, rmax, rcl;
  logic [15:0]        amin, amax;
  logic [15:0]        pw_nxt, pw_r;

  // Stage one: classify the command and form |v * (max - min)|.
  always_comb begin
    v       = sp_ok ? sp_val : '0;
    diff    = $signed({1'b0, par.pmax}) - $signed({1'b0, par.pmin});
    neg_nxt = diff[16];
    dmag    = neg_nxt ? 16'(-diff) : diff[15:0];
    vmag    = v[12:0];
    if (disarmed || v < 0 || v > $signed(16'(CMD_TOP))) begin
      sel_nxt = SEL_DEF;
    end else if (v == 0) begin
      sel_nxt = SEL_LO;
    end else if (v == $signed(16'(CMD_TOP))) begin
      sel_nxt = SEL_HI;
    end else begin
      sel_nxt = SEL_LIN;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      sel_r <= sel_nxt;
      neg_r <= neg_nxt;
      lo_r  <= par.pmin;
      hi_r  <= par.pmax;
      def_r <= par.pdef;
      mag_r <= vmag * dmag;
    end
  end

  // Stage two: m = a*8192 + b = (a + s1)*8191 + t with t below 2*8191,
  // so the quotient needs only adds and one compare.
  always_comb begin
    quo_a = mag_r[28:13];
    s     = {1'b0, quo_a} + {4'b0, mag_r[12:0]};
    t     = {10'b0, s[16:13]} + {1'b0, s[12:0]};
    ge    = t >= {1'b0, CMD_TOP};
    rnz   = ge ? (t != {1'b0, CMD_TOP}) : (t != '0);
    q     = {1'b0, quo_a} + {13'b0, s[16:13]} + {16'b0, ge};
    qc    = q + {16'b0, rnz};
    // Negative slope rounds toward minus infinity, so the magnitude rounds up.
    res   = neg_r ? ($signed({2'b0, lo_r}) - $signed({1'b0, qc}))
                  : ($signed({2'b0, lo_r}) + $signed({1'b0, q}));
    amin  = (lo_r < hi_r) ? lo_r : hi_r;
    amax  = (lo_r < hi_r) ? hi_r : lo_r;
    rmin  = $signed({2'b0, amin});
    rmax  = $signed({2'b0, amax});
    if (res < rmin) begin
      rcl = rmin;
    end else if (res > rmax) begin
      rcl = rmax;
    end else begin
      rcl = res;
    end
    case (sel_r)
      SEL_DEF: pw_nxt = def_r;
      SEL_LO:  pw_nxt = lo_r;
      SEL_HI:  pw_nxt = hi_r;
      default: pw_nxt = rcl[15:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (div_en) begin
      pw_r <= pw_nxt;
    end
  end

  assign pw = pw_r;

endmodule

`default_nettype wire

/* sv/servo_command_to_pwm_mapper_top.sv */
// Top level of the servo command to PWM mapper: sequencer, arming timer and output register.
// Depends on scpm_pkg, scpm_ram (setpoint and parameter memories) and scpm_map.
//
//   Channel  | Direction | Handshake             | Beat contents
//   ---------+-----------+-----------------------+------------------------------------------
//   in_      | input     | in_valid / in_ready   | one command (func plus its operands)
//   out_     | output    | out_valid / out_ready | one channel pulse width, last flag
//
// Init, update, set setpoint and set arming execute in the cycle their beat is taken;
// in_ready stays high unless a tick is being worked or an init result waits for space.
// A tick walks the channels one at a time through both memories: parameter read, setpoint
// read, multiply, divide and output load; the output load waits for a free output slot.
// Reset (rst_n low, synchronous) clears all memory valid bits, the init flags, the arming
// time and the output valid flag; no clearing pass is needed.
// A result sitting in the output register does not block the next command beat.
`default_nettype none

module servo_command_to_pwm_mapper_top #(
  parameter int unsigned NUM_CHANNELS  = 8,
  parameter int unsigned NUM_SETPOINTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_func,
  input  logic [2:0]         in_channel,
  input  logic [7:0]         in_map_source,
  input  logic [15:0]        in_pulse_min,
  input  logic [15:0]        in_pulse_max,
  input  logic [15:0]        in_pulse_default,
  input  logic [7:0]         in_setpoint_index,
  input  logic signed [15:0] in_command_value,
  input  logic               in_arm_flag,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_channel_index,
  output logic [15:0]        out_pulse_width,
  output logic               out_last
);
  import scpm_pkg::*;

  localparam int unsigned CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned SP_AW = (NUM_SETPOINTS > 1) ? $clog2(NUM_SETPOINTS) : 1;

  state_t                  state_r, state_nxt;
  logic [CH_AW-1:0]        ch_cnt_r, ch_cnt_nxt;
  logic [31:0]             arm_time_r, arm_time_nxt;
  logic                    disarm_r, disarm_nxt;
  logic [NUM_CHANNELS-1:0] init_r, init_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [2:0]              out_ch_r, out_ch_nxt;
  logic [15:0]             out_pw_r, out_pw_nxt;
  logic                    out_last_r, out_last_nxt;
  logic [2:0]              pend_ch_r, pend_ch_nxt;
  logic [15:0]             pend_pw_r, pend_pw_nxt;

  // Memory ports.
  logic                    par_we, par_re;
  logic [CH_AW-1:0]        par_waddr, par_raddr;
  par_t                    par_wdata, par_rd;
  logic [PAR_W-1:0]        par_rdata;
  logic                    sp_we, sp_re;
  logic [SP_AW-1:0]        sp_waddr, sp_raddr;
  logic [15:0]             sp_wdata, sp_rdata;

  logic                    ch_ok, src_ok, idx_ok, rd_src_ok, tick_last, out_free;
  logic [15:0]             map_pw;

  scpm_ram #(.WIDTH(PAR_W), .DEPTH(NUM_CHANNELS)) u_par_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .re    (par_re),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  scpm_ram #(.WIDTH(16), .DEPTH(NUM_SETPOINTS)) u_sp_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (sp_we),
    .waddr (sp_waddr),
    .wdata (sp_wdata),
    .re    (sp_re),
    .raddr (sp_raddr),
    .rdata (sp_rdata)
  );

  assign par_rd = par_t'(par_rdata);

  scpm_map u_map (
    .clk      (clk),
    .mul_en   (state_r == S_MUL),
    .div_en   (state_r == S_DIV),
    .sp_val   ($signed(sp_rdata)),
    .sp_ok    (rd_src_ok),
    .par      (par_rd),
    .disarmed (disarm_r),
    .pw       (map_pw)
  );

  always_comb begin
    ch_ok     = 32'(in_channel) < NUM_CHANNELS;
    src_ok    = 32'(in_map_source) < NUM_SETPOINTS;
    idx_ok    = 32'(in_setpoint_index) < NUM_SETPOINTS;
    rd_src_ok = 32'(par_rd.src) < NUM_SETPOINTS;
    tick_last = 32'(ch_cnt_r) == NUM_CHANNELS - 1;
    out_free  = !out_valid_r || out_ready;
  end

  // Sequencer. Memory writes happen only in idle, reads only while a tick is
  // walked, and no beat is taken during a tick, so accesses never overlap.
  always_comb begin
    state_nxt     = state_r;
    ch_cnt_nxt    = ch_cnt_r;
    arm_time_nxt  = arm_time_r;
    disarm_nxt    = disarm_r;
    init_nxt      = init_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ch_nxt    = out_ch_r;
    out_pw_nxt    = out_pw_r;
    out_last_nxt  = out_last_r;
    pend_ch_nxt   = pend_ch_r;
    pend_pw_nxt   = pend_pw_r;
    par_we        = 1'b0;
    par_waddr     = CH_AW'(in_channel);
    par_wdata     = '{src: in_map_source, pmin: in_pulse_min, pmax: in_pulse_max,
                      pdef: in_pulse_default};
    par_re        = 1'b0;
    par_raddr     = ch_cnt_r;
    sp_we         = 1'b0;
    sp_waddr      = SP_AW'(in_setpoint_index);
    sp_wdata      = in_command_value;
    sp_re         = 1'b0;
    sp_raddr      = SP_AW'(par_rd.src);
    in_ready      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_func)
            FUNC_INIT: begin
              if (ch_ok) begin
                par_we = 1'b1;
                if (src_ok) begin
                  sp_we    = 1'b1;
                  sp_waddr = SP_AW'(in_map_source);
                  sp_wdata = SP_INIT;
                end
                if (!init_r[CH_AW'(in_channel)]) begin
                  init_nxt[CH_AW'(in_channel)] = 1'b1;
                  if (out_free) begin
                    out_valid_nxt = 1'b1;
                    out_ch_nxt    = in_channel;
                    out_pw_nxt    = in_pulse_default;
                    out_last_nxt  = 1'b1;
                  end else begin
                    pend_ch_nxt = in_channel;
                    pend_pw_nxt = in_pulse_default;
                    state_nxt   = S_INIT_OUT;
                  end
                end
              end
            end
            FUNC_UPDATE: begin
              par_we = ch_ok;
            end
            FUNC_SETPOINT: begin
              sp_we = idx_ok;
            end
            FUNC_ARM: begin
              arm_time_nxt = in_arm_flag ? in_now_ms : '0;
            end
            FUNC_TICK: begin
              disarm_nxt = 32'(arm_time_r + ARM_HOLD_MS) < in_now_ms;
              ch_cnt_nxt = '0;
              state_nxt  = S_PAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_INIT_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = pend_ch_r;
          out_pw_nxt    = pend_pw_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_PAR: begin
        par_re    = 1'b1;
        state_nxt = S_SRC;
      end
      S_SRC: begin
        sp_re     = rd_src_ok;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = 3'(ch_cnt_r);
          out_pw_nxt    = map_pw;
          out_last_nxt  = tick_last;
          if (tick_last) begin
            state_nxt = S_IDLE;
          end else begin
            ch_cnt_nxt = CH_AW'(ch_cnt_r + 1'b1);
            state_nxt  = S_PAR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_time_r  <= '0;
      init_r      <= '0;
      out_valid_r <= 1'b0;
      disarm_r    <= 1'b0;
      ch_cnt_r    <= '0;
    end else begin
      arm_time_r  <= arm_time_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      disarm_r    <= disarm_nxt;
      ch_cnt_r    <= ch_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ch_r   <= out_ch_nxt;
    out_pw_r   <= out_pw_nxt;
    out_last_r <= out_last_nxt;
    pend_ch_r  <= pend_ch_nxt;
    pend_pw_r  <= pend_pw_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_channel_index = out_ch_r;
  assign out_pulse_width   = out_pw_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

/* sv/scpm_chk.sv */
// Port-level checker for the servo command to PWM mapper, bound to the top level.
// Depends on scpm_pkg for the operation codes.
`default_nettype none

module scpm_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [2:0]         in_func,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_channel_index,
  input logic [15:0]        out_pulse_width,
  input logic               out_last
);
  import scpm_pkg::*;

  // A result beat that is stalled keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel_index) &&
      $stable(out_pulse_width) && $stable(out_last))
    else $error("stalled result beat changed");

  // A taken tick beat must be followed by in_ready low, as the walk closes the input.
  a_tick_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_func == FUNC_TICK |=> !in_ready)
    else $error("command taken right after a tick");

  // Only a tick gives non-final results, and the input is closed during a tick.
  a_mid_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready)
    else $error("non-final result while input open");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind servo_command_to_pwm_mapper_top scpm_chk u_scpm_chk (.*);

`default_nettype wire
